// ----- hw/rtl/arc_pkg.sv -----
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types, request codes and controller interface for the address
// resolution cache.
// ----------------------------------------------------------------------------
package arc_pkg;

	localparam int TABLE_ENTRIES_DEF = 32;
	localparam logic [15:0] TIMEOUT_RST = 16'd15;
	localparam logic [15:0] LFSR_SEED = 16'hACE1;

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] ip_addr;
		logic [47:0] mac_addr;
	} in_item_t;

	typedef struct packed {
		logic        hit;
		logic [47:0] mac_out;
		logic [4:0]  slot_index;
		logic        evicted;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RAND,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;      // capture request, reset scan
		logic scan;       // walk the table
		logic lfsr_step;  // advance replacement LFSR
		logic rand_step;  // one step of the modulo reduction
		logic write;      // write the chosen slot
		logic load;       // load the result register
	} cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       scan_done;
		logic       found;
		logic       have_free;
		logic       rand_done;
		logic       out_free;
	} status_t;

endpackage

// ----- hw/rtl/address_resolution_cache.sv -----
// ----------------------------------------------------------------------------
// address_resolution_cache
// IPv4 to MAC cache with aging and pseudo-random replacement.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_stall/in_data: lookup, insert or refresh,
// and a one-second tick that ages the table. Each request gives exactly one
// result on out_valid/out_stall/out_data. cfg_wr_en/cfg_wr_data set the
// entry timeout in seconds at any idle time.
// A request walks the table one entry per cycle through a single read port
// of the entry memories. After the walk, and any write, the controller waits
// in its done state until the output register is free, loads the result
// there and returns to idle, where the next request is taken. A lookup that
// matches a slot stops the walk early, and so does a refresh. An insert adds
// a write step; into a full table the write is preceded by the LFSR step and
// its reduction modulo TABLE_ENTRIES by reciprocal multiplication. The unused
// request code skips the walk and goes straight to the done state.
// in_stall is high while a request is being worked. A finished result sits
// in the output register; while the receiver stalls it holds, the next
// request is still taken and walked, and only its result waits for the
// register to free up.
// Reset clears all valid bits and the seconds counter, seeds the LFSR and
// sets the timeout to 15; no clearing pass is needed.
// ----------------------------------------------------------------------------
module address_resolution_cache #(
	parameter int TABLE_ENTRIES = arc_pkg::TABLE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  arc_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output arc_pkg::out_item_t out_data,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data
);
	import arc_pkg::*;

	cmd_t    cmd;
	status_t st;

	arc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_req   (in_data.req_type),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	arc_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

// ----- hw/rtl/arc_ctrl.sv -----
// ----------------------------------------------------------------------------
// arc_ctrl
// Request sequencer: accepts a request, runs the table walk, the random slot
// reduction and the write, then hands the result to the output register.
// ----------------------------------------------------------------------------
module arc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     in_req,
	output logic           in_stall,
	input  arc_pkg::status_t st,
	output arc_pkg::cmd_t    cmd
);
	import arc_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_req == REQ_LOOKUP || in_req == REQ_INSERT || in_req == REQ_TICK)
						state_nxt = ST_SCAN;
					else
						state_nxt = ST_DONE;
				end
			end
			ST_SCAN: begin
				if (st.scan_done) begin
					if (st.req != REQ_INSERT)
						state_nxt = ST_DONE;
					else if (st.found || st.have_free)
						state_nxt = ST_WRITE;
					else
						state_nxt = ST_RAND;
				end
			end
			ST_RAND: begin
				if (st.rand_done)
					state_nxt = ST_WRITE;
			end
			ST_WRITE: state_nxt = ST_DONE;
			ST_DONE: begin
				if (st.out_free)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:  cmd.start = accept;
			ST_SCAN: begin
				cmd.scan = 1'b1;
				cmd.lfsr_step = st.scan_done && (st.req == REQ_INSERT) &&
					!st.found && !st.have_free;
			end
			ST_RAND:  cmd.rand_step = 1'b1;
			ST_WRITE: cmd.write = 1'b1;
			ST_DONE:  cmd.load = st.out_free;
			default:  cmd = '0;
		endcase
	end

	ap_load_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_IDLE)
		else $error("result loaded outside the done step");

	ap_write_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> $past(state_q) == ST_SCAN || $past(state_q) == ST_RAND)
		else $error("slot written without a completed walk");

	ap_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> in_stall)
		else $error("new request taken while busy");

endmodule

// ----- hw/rtl/arc_datapath.sv -----
// ----------------------------------------------------------------------------
// arc_datapath
// Entry storage, valid bits, table walk compare, aging, replacement LFSR with
// its modulo reduction, and the result register.
// ----------------------------------------------------------------------------
module arc_datapath #(
	parameter int TABLE_ENTRIES = arc_pkg::TABLE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  arc_pkg::in_item_t  in_data,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  arc_pkg::cmd_t      cmd,
	output arc_pkg::status_t   st,
	output logic               out_valid,
	input  logic               out_stall,
	output arc_pkg::out_item_t out_data
);
	import arc_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);
	localparam int SW = IW + 5;
	localparam logic [15:0] NMOD = 16'(TABLE_ENTRIES);
	// ceil(2^RSH / TABLE_ENTRIES) gives the exact quotient of any 16-bit value
	localparam int RSH = 16 + $clog2(TABLE_ENTRIES);
	localparam logic [17:0] RECIP = 18'(((1 << RSH) + TABLE_ENTRIES - 1) / TABLE_ENTRIES);

	// Entry storage
	logic [31:0] ip_mem    [TABLE_ENTRIES];
	logic [47:0] mac_mem   [TABLE_ENTRIES];
	logic [31:0] stamp_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	// Request
	logic [1:0]  req_q;
	logic [31:0] ip_q;
	logic [47:0] mac_q;
	logic [15:0] timeout_q;
	logic [31:0] seconds_q;
	logic [15:0] lfsr_q;

	// Walk
	logic [IW-1:0] rd_idx_q;
	logic          issued_all_q;
	logic          rd_v_s1;
	logic [IW-1:0] idx_s1;
	logic [31:0]   ip_rd_s1;
	logic [47:0]   mac_rd_s1;
	logic [31:0]   stamp_rd_s1;

	logic          found_q;
	logic [IW-1:0] hit_idx_q;
	logic [47:0]   mac_hit_q;
	logic          free_q;
	logic [IW-1:0] free_idx_q;

	// Modulo reduction: multiply by the reciprocal, then subtract quotient * N
	logic [15:0] rem_q;
	logic        step_q;
	logic [33:0] prod_q;

	logic          out_valid_q;
	out_item_t     out_q;

	logic          cmp_v;
	logic          ent_valid;
	logic          match_now;
	logic          free_now;
	logic          expire_now;
	logic [31:0]   age;
	logic          issue_en;
	logic [15:0]   lfsr_nxt;
	logic [15:0]   quot;
	logic [15:0]   quot_n;
	logic [IW-1:0] tgt;
	logic [SW-1:0] tgt_wide;
	logic [SW-1:0] hit_wide;
	out_item_t     res;

	assign cmp_v      = rd_v_s1 && cmd.scan;
	assign ent_valid  = valid_q[idx_s1];
	assign age        = seconds_q - stamp_rd_s1;
	assign match_now  = cmp_v && (req_q != REQ_TICK) && ent_valid && (ip_rd_s1 == ip_q);
	assign free_now   = cmp_v && !ent_valid;
	assign expire_now = cmp_v && (req_q == REQ_TICK) && ent_valid &&
		(age > {16'd0, timeout_q});
	assign issue_en   = cmd.scan && !issued_all_q && !match_now;

	assign lfsr_nxt = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
	assign quot     = 16'(prod_q >> RSH);
	assign quot_n   = quot * NMOD;

	// Slot to write: refreshed match, else first free, else reduced LFSR value
	always_comb begin
		priority if (found_q)
			tgt = hit_idx_q;
		else if (free_q)
			tgt = free_idx_q;
		else
			tgt = rem_q[IW-1:0];
	end

	assign tgt_wide = SW'(tgt);
	assign hit_wide = SW'(hit_idx_q);

	assign st.req       = req_q;
	assign st.scan_done = cmp_v && (match_now || idx_s1 == LAST);
	assign st.found     = found_q || match_now;
	assign st.have_free = free_q || free_now;
	assign st.rand_done = cmd.rand_step && !step_q;
	assign st.out_free  = !out_valid_q || !out_stall;

	always_comb begin
		res = '0;
		unique case (req_q)
			REQ_LOOKUP: begin
				res.hit = found_q;
				if (found_q) begin
					res.mac_out    = mac_hit_q;
					res.slot_index = hit_wide[4:0];
				end
			end
			REQ_INSERT: begin
				res.hit        = found_q;
				res.slot_index = tgt_wide[4:0];
				res.evicted    = !found_q && !free_q;
			end
			default: res = '0;
		endcase
	end

	// Memories: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			ip_mem[tgt]    <= ip_q;
			mac_mem[tgt]   <= mac_q;
			stamp_mem[tgt] <= seconds_q;
		end
		ip_rd_s1    <= ip_mem[rd_idx_q];
		mac_rd_s1   <= mac_mem[rd_idx_q];
		stamp_rd_s1 <= stamp_mem[rd_idx_q];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ip_q  <= in_data.ip_addr;
			mac_q <= in_data.mac_addr;
		end
		idx_s1 <= rd_idx_q;
		if (match_now) begin
			hit_idx_q <= idx_s1;
			mac_hit_q <= mac_rd_s1;
		end
		if (free_now && !free_q)
			free_idx_q <= idx_s1;
		if (cmd.rand_step && step_q)
			prod_q <= 34'(rem_q) * 34'(RECIP);
		if (cmd.load)
			out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			req_q        <= REQ_LOOKUP;
			timeout_q    <= TIMEOUT_RST;
			seconds_q    <= '0;
			lfsr_q       <= LFSR_SEED;
			rd_idx_q     <= '0;
			issued_all_q <= 1'b0;
			rd_v_s1      <= 1'b0;
			found_q      <= 1'b0;
			free_q       <= 1'b0;
			rem_q        <= '0;
			step_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en)
				timeout_q <= cfg_wr_data;

			rd_v_s1 <= issue_en;
			if (cmd.start) begin
				req_q        <= in_data.req_type;
				rd_idx_q     <= '0;
				issued_all_q <= 1'b0;
				found_q      <= 1'b0;
				free_q       <= 1'b0;
				if (in_data.req_type == REQ_TICK)
					seconds_q <= seconds_q + 32'd1;
			end else if (issue_en) begin
				if (rd_idx_q == LAST)
					issued_all_q <= 1'b1;
				else
					rd_idx_q <= rd_idx_q + IW'(1);
			end

			if (match_now)
				found_q <= 1'b1;
			if (free_now)
				free_q <= 1'b1;
			if (expire_now)
				valid_q[idx_s1] <= 1'b0;

			if (cmd.lfsr_step) begin
				lfsr_q <= lfsr_nxt;
				rem_q  <= lfsr_nxt;
				step_q <= 1'b1;
			end else if (cmd.rand_step) begin
				if (!step_q)
					rem_q <= rem_q - quot_n;
				step_q <= 1'b0;
			end

			if (cmd.write)
				valid_q[tgt] <= 1'b1;

			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	ap_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |=> valid_q[$past(tgt)])
		else $error("written slot not marked valid");

	ap_evict_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && res.evicted |-> &valid_q)
		else $error("eviction reported with a free slot");

	ap_rand_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write && !found_q && !free_q |-> rem_q < NMOD)
		else $error("random slot out of range");

	ap_out_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.load))
		else $error("result raised without a load");

endmodule
